[sv/ism_pkg.sv]
// ism_pkg: types, constants and opcode codes for the integer stack machine
// no dependencies
`default_nettype none
package ism_pkg;
    localparam int STACK_DEPTH = 128;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 8;

    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_MOD  = 5'd5;
    localparam logic [4:0] OP_POW  = 5'd6;
    localparam logic [4:0] OP_EQ   = 5'd7;
    localparam logic [4:0] OP_NE   = 5'd8;
    localparam logic [4:0] OP_LT   = 5'd9;
    localparam logic [4:0] OP_GT   = 5'd10;
    localparam logic [4:0] OP_LE   = 5'd11;
    localparam logic [4:0] OP_GE   = 5'd12;
    localparam logic [4:0] OP_AND  = 5'd13;
    localparam logic [4:0] OP_OR   = 5'd14;
    localparam logic [4:0] OP_NOT  = 5'd15;
    localparam logic [4:0] OP_NEG  = 5'd16;
    localparam logic [4:0] OP_HALT = 5'd17;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVER    = 3'd1;
    localparam logic [2:0] ST_UNDER   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [1:0] MM_RUN  = 2'd0;
    localparam logic [1:0] MM_HALT = 2'd1;
    localparam logic [1:0] MM_ERR  = 2'd2;

    localparam logic [31:0] MAX_MAG = 32'h7FFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load_in;     // capture input word
        logic pop;         // decrement fill
        logic push;        // write result at fill, increment fill
        logic cap_r;       // latch read data into right operand
        logic cap_l;       // latch read data into left operand
        logic alu_go;      // start iterative / simple op
        logic cap_top;     // latch top read data
        logic set_mode;
        logic [1:0] mode_val;
    } ism_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [4:0] op;
        logic       restart;
        logic       empty;
        logic       full;
        logic       alu_done;
        logic       alu_bad;
        logic [1:0] mode;
    } ism_stat_t;
endpackage
`default_nettype wire

[sv/integer_stack_machine.sv]
// integer_stack_machine: top level, controller plus datapath
// depends on ism_pkg, ism_ctrl, ism_datapath
//
// channel | handshake                | word
// input   | in_valid / in_ready      | mode, immediate, restart
// output  | out_valid / out_ready    | status, top_value, depth, run_state
//
// one word at a time: a new word is accepted only after the result has been taken.
// div/mod use a 32-step divider and pow loops through up to 31 multiplies.
// the single-port stack ram sets the pop and top-read steps.
// reset empties the stack and sets running; the result is held until taken.
`default_nettype none
module integer_stack_machine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [4:0]  mode,
    input  wire logic [31:0] immediate,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      top_value,
    output logic [7:0]       depth,
    output logic [1:0]       run_state
);
    ism_pkg::ism_cmd_t  cmd;
    ism_pkg::ism_stat_t stat;

    ism_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .stat      (stat),
        .cmd       (cmd)
    );

    ism_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode_in    (mode),
        .imm_in     (immediate),
        .restart_in (restart),
        .top_out    (top_value),
        .depth_out  (depth),
        .mode_out   (run_state)
    );
endmodule
`default_nettype wire

[sv/ism_ram.sv]
// ism_ram: generic single-port ram, registered read
// no dependencies
`default_nettype none
module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[sv/ism_alu.sv]
// ism_alu: arithmetic unit with iterative divider and power loop
// depends on ism_pkg
`default_nettype none
module ism_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [4:0]  op,
    input  wire logic [31:0] lhs,
    input  wire logic [31:0] rhs,
    output logic             done,
    output logic             bad,
    output logic [31:0]      result
);
    typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW, A_MUL} astate_t;
    astate_t state_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg, rem_reg, dvd_reg, dvs_reg;
    logic        qneg_reg, rneg_reg;
    logic [31:0] mag_reg, ab_reg;
    logic [4:0]  exp_reg;
    logic        pneg_reg;
    logic [63:0] prod_reg;

    logic signed [31:0] sl, sr;
    logic [32:0] rem_sh, rem_sub;
    logic [31:0] simple;
    logic [31:0] abs_l, abs_r;
    assign sl = lhs;
    assign sr = rhs;
    assign abs_l = sl[31] ? 32'(-lhs) : lhs;
    assign abs_r = sr[31] ? 32'(-rhs) : rhs;
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // combinational results for the simple ops
    always_comb
    begin
        case (op)
            ism_pkg::OP_ADD: simple = lhs + rhs;
            ism_pkg::OP_SUB: simple = lhs - rhs;
            ism_pkg::OP_EQ:  simple = {31'd0, sl == sr};
            ism_pkg::OP_NE:  simple = {31'd0, sl != sr};
            ism_pkg::OP_LT:  simple = {31'd0, sl < sr};
            ism_pkg::OP_GT:  simple = {31'd0, sl > sr};
            ism_pkg::OP_LE:  simple = {31'd0, sl <= sr};
            ism_pkg::OP_GE:  simple = {31'd0, sl >= sr};
            ism_pkg::OP_AND: simple = {31'd0, (lhs != 32'd0) && (rhs != 32'd0)};
            ism_pkg::OP_OR:  simple = {31'd0, (lhs != 32'd0) || (rhs != 32'd0)};
            ism_pkg::OP_NOT: simple = {31'd0, lhs == 32'd0};
            ism_pkg::OP_NEG: simple = 32'd0 - lhs;
            default:         simple = 32'd0;
        endcase
    end

    // sequencing of all ops: simple ops, multiply, divider and power loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done      <= 1'b0;
            bad       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (go)
                    begin
                        bad <= 1'b0;
                        case (op)
                            ism_pkg::OP_MUL:
                            begin
                                prod_reg  <= lhs * rhs;
                                state_reg <= A_MUL;
                            end
                            ism_pkg::OP_DIV, ism_pkg::OP_MOD:
                            begin
                                if (rhs == 32'd0)
                                begin
                                    bad  <= 1'b1;
                                    done <= 1'b1;
                                end
                                else
                                begin
                                    dvd_reg   <= abs_l;
                                    dvs_reg   <= abs_r;
                                    rem_reg   <= 32'd0;
                                    quo_reg   <= 32'd0;
                                    qneg_reg  <= sl[31] ^ sr[31];
                                    rneg_reg  <= sl[31];
                                    cnt_reg   <= 6'd32;
                                    state_reg <= A_DIV;
                                end
                            end
                            ism_pkg::OP_POW:
                            begin
                                done <= 1'b1;
                                if (sr[31])
                                begin
                                    bad <= 1'b1;
                                end
                                else if (rhs == 32'd0 || lhs == 32'd1)
                                begin
                                    result <= 32'd1;
                                end
                                else if (lhs == 32'd0)
                                begin
                                    result <= 32'd0;
                                end
                                else if (lhs == 32'hFFFF_FFFF)
                                begin
                                    result <= rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                end
                                else if (rhs > 32'd31 || (abs_l > 32'd2 && rhs > 32'd15))
                                begin
                                    bad <= 1'b1;
                                end
                                else
                                begin
                                    done      <= 1'b0;
                                    mag_reg   <= 32'd1;
                                    ab_reg    <= abs_l;
                                    exp_reg   <= rhs[4:0];
                                    pneg_reg  <= sl[31] & rhs[0];
                                    state_reg <= A_POW;
                                    cnt_reg   <= 6'd0;
                                end
                            end
                            default:
                            begin
                                result <= simple;
                                done   <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    result    <= prod_reg[31:0];
                    done      <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV:
                begin
                    // restoring division, one bit a cycle
                    if (cnt_reg == 6'd0)
                    begin
                        if (op == ism_pkg::OP_DIV)
                        begin
                            result <= qneg_reg ? 32'(-quo_reg) : quo_reg;
                        end
                        else
                        begin
                            result <= rneg_reg ? 32'(-rem_reg) : rem_reg;
                        end
                        done      <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[30:0], 1'b0};
                        if (!rem_sub[32])
                        begin
                            rem_reg <= rem_sub[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                A_POW:
                begin
                    // mag > MAX/ab  <=>  mag*ab > MAX (integers); product fits 64 bits
                    if (exp_reg == 5'd0)
                    begin
                        result    <= pneg_reg ? 32'(-mag_reg) : mag_reg;
                        done      <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                    else if (cnt_reg[0] == 1'b0)
                    begin
                        prod_reg <= mag_reg * ab_reg;
                        cnt_reg  <= 6'd1;
                    end
                    else
                    begin
                        cnt_reg <= 6'd0;
                        if (prod_reg > {32'd0, ism_pkg::MAX_MAG})
                        begin
                            bad       <= 1'b1;
                            done      <= 1'b1;
                            state_reg <= A_IDLE;
                        end
                        else
                        begin
                            mag_reg <= prod_reg[31:0];
                            exp_reg <= exp_reg - 5'd1;
                        end
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/ism_datapath.sv]
// ism_datapath: stack ram, fill counter, operand registers, alu and output word
// depends on ism_pkg, ism_ram, ism_alu
`default_nettype none
module ism_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ism_pkg::ism_cmd_t cmd,
    output ism_pkg::ism_stat_t     stat,
    input  wire logic [4:0]        mode_in,
    input  wire logic [31:0]       imm_in,
    input  wire logic              restart_in,
    output logic [31:0]            top_out,
    output logic [ism_pkg::DEPTH_W-1:0] depth_out,
    output logic [1:0]             mode_out
);
    logic [4:0]  op_reg;
    logic [31:0] imm_reg, l_reg, r_reg;
    logic        restart_reg;
    logic [ism_pkg::FILL_W-1:0] fill_reg;
    logic [1:0]  mm_reg;
    logic [ism_pkg::ADDR_W-1:0] addr;
    logic [31:0] rdata, wdata, alu_res;
    logic        alu_done, alu_bad;
    logic        use_alu;

    assign use_alu = (op_reg != ism_pkg::OP_PUSH);
    assign wdata   = use_alu ? alu_res : imm_reg;
    assign addr    = cmd.push ? fill_reg[ism_pkg::ADDR_W-1:0]
                              : ism_pkg::ADDR_W'(fill_reg - 1'b1);

    ism_ram #(.WIDTH(32), .DEPTH(ism_pkg::STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    ism_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.alu_go),
        .op     (op_reg),
        .lhs    (l_reg),
        .rhs    (r_reg),
        .done   (alu_done),
        .bad    (alu_bad),
        .result (alu_res)
    );

    // control state: fill and machine mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            mm_reg   <= ism_pkg::MM_RUN;
        end
        else
        begin
            if (cmd.push)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.set_mode)
            begin
                mm_reg <= cmd.mode_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= mode_in;
            imm_reg     <= imm_in;
            restart_reg <= restart_in;
        end
        if (cmd.cap_r)
        begin
            r_reg <= rdata;
        end
        if (cmd.cap_l)
        begin
            l_reg <= rdata;
        end
        if (cmd.cap_top)
        begin
            top_out <= (fill_reg == '0) ? 32'd0 : rdata;
        end
    end

    assign depth_out = ism_pkg::DEPTH_W'(fill_reg);
    assign mode_out  = mm_reg;

    assign stat.op       = op_reg;
    assign stat.restart  = restart_reg;
    assign stat.empty    = (fill_reg == '0);
    assign stat.full     = (fill_reg >= ism_pkg::FILL_W'(ism_pkg::STACK_DEPTH));
    assign stat.alu_done = alu_done;
    assign stat.alu_bad  = alu_bad;
    assign stat.mode     = mm_reg;
endmodule
`default_nettype wire

[sv/ism_ctrl.sv]
// ism_ctrl: sequencer for one instruction word, handshake and status
// depends on ism_pkg
`default_nettype none
module ism_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             status,
    input  wire ism_pkg::ism_stat_t stat,
    output ism_pkg::ism_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_POPR, S_CAPR, S_POPL, S_CAPL, S_EXEC, S_WAIT,
        S_PUSH, S_TOPRD, S_TOPCAP, S_OUT
    } state_t;
    state_t state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       unary_reg, unary_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;

    // next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        unary_next = unary_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next    = ism_pkg::ST_OK;
                unary_next = 1'b0;
                if (stat.restart || stat.mode == ism_pkg::MM_RUN)
                begin
                    if (stat.restart)
                    begin
                        cmd.set_mode = 1'b1;
                        cmd.mode_val = ism_pkg::MM_RUN;
                    end
                    case (stat.op) inside
                        ism_pkg::OP_PUSH:
                        begin
                            if (stat.full)
                            begin
                                st_next    = ism_pkg::ST_OVER;
                                state_next = S_TOPRD;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        ism_pkg::OP_HALT:
                        begin
                            cmd.set_mode = 1'b1;
                            cmd.mode_val = ism_pkg::MM_HALT;
                            state_next   = S_TOPRD;
                        end
                        ism_pkg::OP_NOT, ism_pkg::OP_NEG:
                        begin
                            unary_next = 1'b1;
                            state_next = S_POPR;
                        end
                        [ism_pkg::OP_ADD:ism_pkg::OP_OR]:
                        begin
                            state_next = S_POPR;
                        end
                        default:
                        begin
                            st_next    = ism_pkg::ST_INVALID;
                            state_next = S_TOPRD;
                        end
                    endcase
                end
                else
                begin
                    st_next    = ism_pkg::ST_IGNORED;
                    state_next = S_TOPRD;
                end
            end
            S_POPR:
            begin
                // unary operand goes to the left register
                if (stat.empty)
                begin
                    st_next    = ism_pkg::ST_UNDER;
                    state_next = S_TOPRD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_CAPR;
                end
            end
            S_CAPR:
            begin
                if (unary_reg)
                begin
                    cmd.cap_l  = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.cap_r  = 1'b1;
                    state_next = S_POPL;
                end
            end
            S_POPL:
            begin
                if (stat.empty)
                begin
                    st_next    = ism_pkg::ST_UNDER;
                    state_next = S_TOPRD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_CAPL;
                end
            end
            S_CAPL:
            begin
                cmd.cap_l  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.alu_go = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.alu_done)
                begin
                    if (stat.alu_bad)
                    begin
                        st_next    = ism_pkg::ST_INVALID;
                        state_next = S_TOPRD;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_TOPRD;
            end
            S_TOPRD:
            begin
                // ram reads the new top during this cycle
                if (st_reg == ism_pkg::ST_OVER || st_reg == ism_pkg::ST_UNDER ||
                    st_reg == ism_pkg::ST_INVALID)
                begin
                    cmd.set_mode = 1'b1;
                    cmd.mode_val = ism_pkg::MM_ERR;
                end
                state_next = S_TOPCAP;
            end
            S_TOPCAP:
            begin
                cmd.cap_top = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ism_pkg::ST_OK;
            unary_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            unary_reg <= unary_next;
        end
    end
endmodule
`default_nettype wire
